// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is active.
`define SWS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold.
`define SWS_ASSERT_NEVER(label, expr, msg) \
    `SWS_ASSERT_CLK(label, !(expr), msg)

`endif

// File: hw/rtl/swstat_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package swstat_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int STD_W     = 23;
    localparam int LEN_CFG_W = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 7'd64;
    localparam logic [STD_W-1:0]     STD_MAX   = 23'h7FFFFF;

    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_TRIM = 2'd2;

    typedef struct packed {
        logic       ld_in;
        logic       rd_old;
        logic       upd;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_take;
        logic       walk_start;
        logic       walk_step;
        logic       sq_start;
        logic       ld_out;
    } swstat_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic walk_busy;
        logic div_busy;
        logic sq_busy;
        logic out_full;
    } swstat_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sliding_window_statistics.sv
// Top level: sliding window mean, deviation and trimmed mean.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_valid, cfg_ready | window_len
//  in       | in_valid, in_stall   | sample
//  out      | out_valid, out_stall | stats_valid, window_mean, std_dev,
//           |                      | trim_valid, trimmed_mean
//
//  Per request the shared one-bit-per-cycle divider runs three times over
//  48 + log2(WINDOW_DEPTH) bits and the walk reads one store entry per cycle
//  until every sample held has been read.
//  Reset clears pointers, count and sum; the store is not cleared.
//  A finished result waits in the output register under out_stall while
//  the next request is taken.
`default_nettype none

module sliding_window_statistics
    import swstat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [LEN_CFG_W-1:0]        window_len,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [SAMPLE_W-1:0]  sample,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             stats_valid,
    output logic signed [SAMPLE_W-1:0]       window_mean,
    output logic [STD_W-1:0]                 std_dev,
    output logic                             trim_valid,
    output logic signed [SAMPLE_W-1:0]       trimmed_mean
);

    swstat_cmd_t cmd;
    swstat_sts_t sts;

    assign cfg_ready = 1'b1;

    swstat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    swstat_dp #(
        .DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (window_len),
        .sample_in    (sample),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .stats_valid  (stats_valid),
        .window_mean  (window_mean),
        .std_dev      (std_dev),
        .trim_valid   (trim_valid),
        .trimmed_mean (trimmed_mean)
    );

endmodule

`default_nettype wire

// File: hw/rtl/swstat_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module swstat_div
    import swstat_pkg::*;
#(
    parameter int DW = 54,
    parameter int VW = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               busy,
    output logic [DW-1:0]      quot
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    q_reg, q_next;
    logic [VW-1:0]    r_reg, r_next;
    logic [VW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [VW:0]      rem_sh;
    logic             qbit;

    always_comb
    begin
        rem_sh    = {r_reg, q_reg[DW-1]};
        qbit      = (rem_sh >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DW-2:0], qbit};
            r_next   = qbit ? VW'(rem_sh - {1'b0, d_reg}) : VW'(rem_sh);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// File: hw/rtl/swstat_sqrt.sv
// Bitwise floored integer square root, two input bits per cycle.
`default_nettype none

module swstat_sqrt
    import swstat_pkg::*;
#(
    parameter int IW = 54
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [IW-1:0]       radicand,
    output logic                     busy,
    output logic [(IW+1)/2-1:0]      root
);

    localparam int N     = (IW + 1) / 2;
    localparam int CNT_W = $clog2(N + 1);

    logic [2*N-1:0]   v_reg, v_next;
    logic [N:0]       rem_reg, rem_next;
    logic [N-1:0]     root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [N+2:0]     rem_sh;
    logic [N+2:0]     trial;
    logic             take;

    always_comb
    begin
        rem_sh    = {rem_reg, v_reg[2*N-1:2*N-2]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = (rem_sh >= trial);
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next    = (2*N)'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next    = {v_reg[2*N-3:0], 2'b00};
            rem_next  = take ? (N+1)'(rem_sh - trial) : (N+1)'(rem_sh);
            root_next = {root_reg[N-2:0], take};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: hw/rtl/swstat_dp.sv
// Datapath: sample store, running sum, window walk, divider, root, result register.
`default_nettype none

module swstat_dp
    import swstat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [LEN_CFG_W-1:0]        cfg_data,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,
    input  wire swstat_cmd_t                 cmd,
    output swstat_sts_t                      sts,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic                             stats_valid,
    output logic signed [SAMPLE_W-1:0]       window_mean,
    output logic [STD_W-1:0]                 std_dev,
    output logic                             trim_valid,
    output logic signed [SAMPLE_W-1:0]       trimmed_mean
);

    localparam int AW     = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CW     = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int SUM_W  = SAMPLE_W + AW;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int ACC_W  = SQ_W + AW;
    localparam int ROOT_W = (ACC_W + 1) / 2;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    logic [LEN_CFG_W-1:0]       wl_reg;
    logic [AW-1:0]              wp_reg;
    logic [LEN_W-1:0]           fill_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [LEN_W-1:0]           wcnt_reg;
    logic                       rv_reg;
    logic                       sv_reg;
    logic                       first_reg;
    logic                       out_valid_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [SAMPLE_W-1:0] mx_reg, mn_reg;
    logic signed [SAMPLE_W-1:0] mean_reg, trim_reg;
    logic                       neg_reg;
    logic                       sv_out_reg, tv_out_reg;
    logic signed [SAMPLE_W-1:0] mean_out_reg, trim_out_reg;
    logic [STD_W-1:0]           std_out_reg;

    logic [LEN_W-1:0]           len;
    logic [AW-1:0]              wp_eff;
    logic [LEN_W-1:0]           fill_eff;
    logic                       full_now;
    logic [AW-1:0]              rd_addr;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          diff_abs;
    logic [SQ_W-1:0]            sq_next;
    logic [SUM_W-1:0]           sum_abs;
    logic signed [SUM_W:0]      trim_num;
    logic [SUM_W:0]             trim_abs;
    logic [ACC_W-1:0]           div_a;
    logic [LEN_W-1:0]           div_b;
    logic                       div_neg;
    logic [ACC_W-1:0]           quot;
    logic [SAMPLE_W-1:0]        q_signed;
    logic [ROOT_W-1:0]          root;
    logic [STD_W-1:0]           std_sat;
    logic                       div_busy, sq_busy;

    always_comb
    begin
        if (wl_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (CW'(wl_reg) > CW'(DEPTH))
        begin
            len = LEN_W'(DEPTH);
        end
        else
        begin
            len = LEN_W'(wl_reg);
        end
    end

    assign wp_eff   = (LEN_W'(wp_reg) >= len) ? '0 : wp_reg;
    assign fill_eff = (fill_reg > len) ? len : fill_reg;
    assign full_now = (fill_reg == len);
    assign rd_addr  = cmd.rd_old ? wp_eff : wcnt_reg[AW-1:0];

    // store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            mem[wp_reg] <= x_reg;
        end
        if (cmd.rd_old || cmd.walk_step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= LEN_RESET;
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cfg_we)
        begin
            wl_reg   <= cfg_data;
            wp_reg   <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.rd_old)
        begin
            wp_reg   <= wp_eff;
            fill_reg <= fill_eff;
        end
        else if (cmd.upd)
        begin
            sum_reg  <= sum_reg - (full_now ? SUM_W'(rd_data_reg) : '0) + SUM_W'(x_reg);
            wp_reg   <= ((LEN_W'(wp_reg) + LEN_W'(1)) == len) ? '0 : AW'(wp_reg + AW'(1));
            fill_reg <= full_now ? fill_reg : fill_reg + LEN_W'(1);
        end
    end

    // window walk: read, square, accumulate, track min and max
    assign sts.walk_last = (wcnt_reg == fill_reg - LEN_W'(1));
    assign sts.walk_busy = rv_reg || sv_reg;

    assign diff     = $signed({rd_data_reg[SAMPLE_W-1], rd_data_reg})
                    - $signed({mean_reg[SAMPLE_W-1], mean_reg});
    assign diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    assign sq_next  = diff_abs[SAMPLE_W-1:0] * diff_abs[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg  <= '0;
            rv_reg    <= 1'b0;
            sv_reg    <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.walk_step;
            sv_reg <= rv_reg;
            if (cmd.walk_start)
            begin
                wcnt_reg  <= '0;
                first_reg <= 1'b1;
            end
            else
            begin
                if (cmd.walk_step)
                begin
                    wcnt_reg <= wcnt_reg + LEN_W'(1);
                end
                if (rv_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            x_reg <= sample_in;
        end
        if (rv_reg)
        begin
            sq_reg <= sq_next;
            if (first_reg || rd_data_reg > mx_reg)
            begin
                mx_reg <= rd_data_reg;
            end
            if (first_reg || rd_data_reg < mn_reg)
            begin
                mn_reg <= rd_data_reg;
            end
        end
        if (cmd.walk_start)
        begin
            acc_reg <= '0;
        end
        else if (sv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
    end

    // operands of the shared divider
    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trim_num = (SUM_W+1)'(sum_reg) - (SUM_W+1)'(mx_reg) - (SUM_W+1)'(mn_reg);
    assign trim_abs = trim_num[SUM_W] ? (SUM_W+1)'(-trim_num) : (SUM_W+1)'(trim_num);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_VAR:
            begin
                div_a   = acc_reg;
                div_b   = len;
                div_neg = 1'b0;
            end
            DIV_TRIM:
            begin
                div_a   = ACC_W'(trim_abs);
                div_b   = fill_reg - LEN_W'(2);
                div_neg = trim_num[SUM_W];
            end
            default:
            begin
                div_a   = ACC_W'(sum_abs);
                div_b   = len;
                div_neg = sum_reg[SUM_W-1];
            end
        endcase
    end

    swstat_div #(
        .DW (ACC_W),
        .VW (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quot     (quot)
    );

    swstat_sqrt #(
        .IW (ACC_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (quot),
        .busy     (sq_busy),
        .root     (root)
    );

    assign sts.div_busy = div_busy;
    assign sts.sq_busy  = sq_busy;

    assign q_signed = neg_reg ? SAMPLE_W'(-quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];
    assign std_sat  = (root > ROOT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= div_neg;
        end
        if (cmd.div_take && cmd.div_sel == DIV_MEAN)
        begin
            mean_reg <= q_signed;
        end
        if (cmd.div_take && cmd.div_sel == DIV_TRIM)
        begin
            trim_reg <= q_signed;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            sv_out_reg   <= full_now;
            mean_out_reg <= full_now ? mean_reg : '0;
            std_out_reg  <= full_now ? std_sat : '0;
            tv_out_reg   <= (fill_reg >= LEN_W'(3));
            trim_out_reg <= (fill_reg >= LEN_W'(3)) ? trim_reg : '0;
        end
    end

    assign sts.out_full  = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign stats_valid   = sv_out_reg;
    assign window_mean   = mean_out_reg;
    assign std_dev       = std_out_reg;
    assign trim_valid    = tv_out_reg;
    assign trimmed_mean  = trim_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/swstat_ctrl.sv
// Sequencer for the per-request steps of the datapath.
`default_nettype none

module swstat_ctrl
    import swstat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output swstat_cmd_t      cmd,
    input  wire swstat_sts_t sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDOLD  = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_MGO    = 4'd3;
    localparam logic [3:0] S_MDIV   = 4'd4;
    localparam logic [3:0] S_WSTART = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_VDIV   = 4'd8;
    localparam logic [3:0] S_TGO    = 4'd9;
    localparam logic [3:0] S_TDIV   = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_RDOLD;
                end
            end
            S_RDOLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_MGO;
            end
            S_MGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MDIV;
            end
            S_MDIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_WSTART;
                end
            end
            S_WSTART:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.div_sel = DIV_VAR;
                if (!sts.walk_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_VDIV;
                end
            end
            S_VDIV:
            begin
                cmd.div_sel = DIV_VAR;
                if (!sts.div_busy)
                begin
                    cmd.sq_start = 1'b1;
                    state_next   = S_TGO;
                end
            end
            S_TGO:
            begin
                cmd.div_sel   = DIV_TRIM;
                cmd.div_start = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_sel = DIV_TRIM;
                if (!sts.div_busy && !sts.sq_busy)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/swstat_chk.sv
// Port-level checker for the sliding window block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module swstat_chk
    import swstat_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic                       stats_valid,
    input wire logic signed [SAMPLE_W-1:0] window_mean,
    input wire logic [STD_W-1:0]           std_dev,
    input wire logic                       trim_valid,
    input wire logic signed [SAMPLE_W-1:0] trimmed_mean
);

    `SWS_ASSERT_CLK(a_busy_after_req, (in_valid && !in_stall) |=> in_stall, "no stall after request")
    `SWS_ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(window_mean) && $stable(std_dev) && $stable(trimmed_mean)), "stalled result changed")
    `SWS_ASSERT_NEVER(a_stats_zero, out_valid && !stats_valid && (window_mean != '0 || std_dev != '0), "stats nonzero while not full")
    `SWS_ASSERT_NEVER(a_trim_zero, out_valid && !trim_valid && trimmed_mean != '0, "trimmed mean nonzero while invalid")

endmodule

bind sliding_window_statistics swstat_chk u_chk (.*);

`default_nettype wire

// File: tb/testbench.sv
// Testbench for sliding_window_statistics: directed and random samples, self-checking.
`timescale 1ns / 100ps

module testbench;
    import swstat_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_PCT   = 13;
    localparam int HOLD_LEN   = 1500;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 300;

    typedef struct {
        logic                stats_ok;
        logic [SAMPLE_W-1:0] mean;
        logic [STD_W-1:0]    dev;
        logic                trim_ok;
        logic [SAMPLE_W-1:0] trim;
    } stats_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [LEN_CFG_W-1:0]       window_len;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic                       stats_valid;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [STD_W-1:0]           std_dev;
    logic                       trim_valid;
    logic signed [SAMPLE_W-1:0] trimmed_mean;

    // predictor state
    longint          win_store [DEPTH];
    int              wr_ptr;
    int              held;
    longint          win_sum;
    logic [LEN_CFG_W-1:0] len_reg;

    stats_t pending_stats[$];
    int     mismatches;
    int     samples_sent;
    int     results_seen;
    int     cfg_writes;
    bit     quiet;
    int     hold_arm;
    int     hold_seen;
    int     hold_left;
    int     dead_cycles;

    sliding_window_statistics #(.WINDOW_DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_len   (window_len),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .stats_valid  (stats_valid),
        .window_mean  (window_mean),
        .std_dev      (std_dev),
        .trim_valid   (trim_valid),
        .trimmed_mean (trimmed_mean)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic stats_t window_stats_step(logic signed [SAMPLE_W-1:0] x);
        stats_t          r;
        int              n;
        longint          m;
        longint          d;
        longint          hi;
        longint          lo;
        longint unsigned acc;
        longint unsigned sd;
        n = (len_reg == 0) ? 1 : (len_reg > DEPTH) ? DEPTH : len_reg;
        if (wr_ptr >= n)
            wr_ptr = 0;
        if (held > n)
            held = n;
        if (held == n)
            win_sum -= win_store[wr_ptr];
        win_store[wr_ptr] = longint'(x);
        win_sum += longint'(x);
        wr_ptr = (wr_ptr + 1) % n;
        if (held < n)
            held++;
        r = '{1'b0, '0, '0, 1'b0, '0};
        if (held == n)
        begin
            m = win_sum / n;
            acc = 0;
            for (int i = 0; i < n; i++)
            begin
                d = win_store[i] - m;
                if (d < 0)
                    d = -d;
                acc += longint'(d) * longint'(d);
            end
            sd = floor_sqrt(acc / n);
            if (sd > STD_MAX)
                sd = STD_MAX;
            r.stats_ok = 1'b1;
            r.mean = m[SAMPLE_W-1:0];
            r.dev = sd[STD_W-1:0];
        end
        if (held >= 3)
        begin
            hi = win_store[0];
            lo = win_store[0];
            for (int i = 1; i < held; i++)
            begin
                if (win_store[i] > hi)
                    hi = win_store[i];
                if (win_store[i] < lo)
                    lo = win_store[i];
            end
            m = (win_sum - hi - lo) / (held - 2);
            r.trim_ok = 1'b1;
            r.trim = m[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
        stats_t e;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = window_stats_step(x);
        pending_stats.push_back(e);
        samples_sent++;
    endtask

    task automatic write_length(logic [LEN_CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_valid  <= 1'b1;
        window_len <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        len_reg = v;
        wr_ptr = 0;
        held = 0;
        win_sum = 0;
        cfg_writes++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
            5, 6:          return SAMPLE_W'($urandom_range(0, 2047) - 1024);
            7:             return 24'sh7FFFFF;
            8:             return 24'sh800000;
            default:       return SAMPLE_W'($urandom_range(0, 255) + 24'sh7FFF00);
        endcase
    endfunction

    task automatic test_reset_length();
        repeat (190) send_sample(rand_sample());
    endtask

    task automatic test_directed_extremes();
        write_length(7'd3);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample(24'sh000000);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        write_length(7'd2);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample(24'sh7FFFFF);
        write_length(7'd0);
        send_sample(24'sh800000);
        send_sample(24'sh123456);
        write_length(7'd1);
        send_sample(-24'sd7);
        send_sample(24'sd7);
        write_length(7'd127);
        repeat (5) send_sample(24'sh7FFFFF);
        write_length(7'd127);
        send_sample(24'sh555555);
        send_sample(24'shAAAAAA);
    endtask

    task automatic test_random_lengths();
        write_length(7'd5);
        repeat (100) send_sample(rand_sample());
        quiet <= 1'b1;
        write_length(7'd17);
        repeat (200) send_sample(rand_sample());
        quiet <= 1'b0;
        write_length(7'd64);
        repeat (300) send_sample(rand_sample());
        write_length(7'd100);
        repeat (150) send_sample(rand_sample());
        write_length(7'd1);
        repeat (60) send_sample(rand_sample());
        write_length(7'd0);
        repeat (40) send_sample(rand_sample());
        for (int p = 0; p < 12; p++)
        begin
            write_length(LEN_CFG_W'($urandom_range(1, 40)));
            repeat (60) send_sample(rand_sample());
        end
    endtask

    task automatic test_output_hold();
        write_length(7'd8);
        @(posedge clk);
        hold_arm <= hold_arm + 1;
        repeat (20) send_sample(rand_sample());
    endtask

    always @(posedge clk)
    begin
        stats_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_stats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t", $time);
                end
                else
                begin
                    e = pending_stats.pop_front();
                    if (stats_valid !== e.stats_ok || window_mean !== e.mean ||
                        std_dev !== e.dev || trim_valid !== e.trim_ok ||
                        trimmed_mean !== e.trim)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: exp %b %0d %0d %b %0d",
                                " got %b %0d %0d %b %0d"},
                                $time, e.stats_ok, $signed(e.mean), e.dev, e.trim_ok,
                                $signed(e.trim), stats_valid, window_mean, std_dev,
                                trim_valid, trimmed_mean);
                    end
                end
            end
            if (hold_arm != hold_seen)
            begin
                hold_seen = hold_arm;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            dead_cycles = 0;
        else
            dead_cycles++;
        if (dead_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        window_len = LEN_RESET;
        in_valid   = 1'b0;
        sample     = '0;
        quiet      = 1'b0;
        hold_arm   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        dead_cycles = 0;
        mismatches = 0;
        samples_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        len_reg    = LEN_RESET;
        wr_ptr     = 0;
        held       = 0;
        win_sum    = 0;
        foreach (win_store[i])
            win_store[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_directed_extremes();
        test_random_lengths();
        test_output_hold();

        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d samples, %0d results, %0d length writes incl. 0, 1 and 127,",
            samples_sent, results_seen, cfg_writes);
        $display("with random idling, a long output hold, and %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
